@@ design/afp_pkg.sv @@
// Shared types, field widths and constants for the adaptive frame pacing block.
// Used by afp_chan_ctrl and adaptive_frame_pacing; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package afp_pkg;

    // Sizing
    localparam int CHANNELS    = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int CH_IDX_W    = $clog2(CHANNELS);

    // Field widths
    localparam int OP_W        = 2;
    localparam int CHANNEL_W   = 4;
    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 5;
    localparam int PCT_W       = 8;
    localparam int INTERVAL_W  = 16;
    localparam int DEPTH_W     = 5;

    // Stream widths (input tdata padded to whole bytes)
    localparam int S_DATA_RAW_W = CHANNEL_W + TIME_W;
    localparam int S_TDATA_W    = ((S_DATA_RAW_W + 7) / 8) * 8;
    localparam int S_TUSER_W    = OP_W;
    localparam int M_DATA_RAW_W = 3 + COUNT_W + PCT_W;
    localparam int M_TDATA_W    = ((M_DATA_RAW_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = INTERVAL_W;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_INTERVAL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IDEAL_DEPTH    = 1'd1;
    localparam logic [INTERVAL_W-1:0]  FRAME_INTERVAL_RST = 16'd40;
    localparam logic [DEPTH_W-1:0]     IDEAL_DEPTH_RST    = 5'd4;

    // Event kinds
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_ARRIVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_PRESENT = 2'd2;

    // Scale constants
    localparam logic [PCT_W-1:0] SCALE_UNITY = 8'd100;
    localparam logic [PCT_W-1:0] SCALE_FLOOR = 8'd50;
    localparam logic [PCT_W-1:0] SCALE_CEIL  = 8'd200;
    localparam logic [PCT_W-1:0] SCALE_STEP  = 8'd5;

    // Divide by 100 via reciprocal multiply: exact for products below 2**24
    localparam int PROD_W       = INTERVAL_W + PCT_W;
    localparam int DIV100_SHIFT = 31;
    localparam int DIV100_MUL_W = 25;
    localparam longint unsigned DIV100_MUL_L =
        ((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = DIV100_MUL_W'(DIV100_MUL_L);
    localparam int DIV_PROD_W   = PROD_W + DIV100_MUL_W;
    localparam int DT_W         = 18;

    typedef struct packed {
        logic [TIME_W-1:0]    now_time;
        logic [CHANNEL_W-1:0] channel;
        logic [OP_W-1:0]      op;
    } afp_item_t;

    // Packed so that present_due lands in bit 0 of tdata
    typedef struct packed {
        logic               dropped;
        logic [PCT_W-1:0]   adjust_percent;
        logic [COUNT_W-1:0] queue_count;
        logic               shown;
        logic               present_due;
    } afp_result_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] frame_interval;
        logic [DEPTH_W-1:0]    ideal_queue_depth;
    } afp_cfg_t;

endpackage

`default_nettype wire

@@ design/afp_chan_ctrl.sv @@
// Per-channel pacing state and the read-modify-write of that state for one item.
// Depends on afp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afp_chan_ctrl import afp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire afp_cfg_t    cfg,
    input  wire logic        item_en,
    input  wire afp_item_t   item,
    output afp_result_t      result
);

    logic [COUNT_W-1:0]    count_reg      [CHANNELS];
    logic                  speeding_reg   [CHANNELS];
    logic [PCT_W-1:0]      pct_reg        [CHANNELS];
    logic [INTERVAL_W-1:0] base_reg       [CHANNELS];
    logic [TIME_W-1:0]     due_time_reg   [CHANNELS];
    logic                  due_valid_reg  [CHANNELS];
    logic [TIME_W-1:0]     last_shown_reg [CHANNELS];
    logic                  first_tick_reg [CHANNELS];
    logic                  seen_reg       [CHANNELS];
    logic                  has_shown_reg  [CHANNELS];

    logic [COUNT_W-1:0]    count_next;
    logic                  speeding_next;
    logic [PCT_W-1:0]      pct_next;
    logic [INTERVAL_W-1:0] base_next;
    logic [TIME_W-1:0]     due_time_next;
    logic                  due_valid_next;
    logic [TIME_W-1:0]     last_shown_next;
    logic                  first_tick_next;
    logic                  seen_next;
    logic                  has_shown_next;

    logic [CH_IDX_W-1:0]   ch;
    logic                  ch_ok;
    logic                  faster;
    logic [PCT_W-1:0]      pct_start;
    logic [PCT_W-1:0]      pct_stepped;
    logic [PROD_W-1:0]     scaled;
    logic [DIV_PROD_W-1:0] scaled_div;
    logic [DT_W-1:0]       dt;
    afp_result_t           res;

    assign ch    = item.channel[CH_IDX_W-1:0];
    assign ch_ok = (int'(item.channel) < CHANNELS);

    // Scale step for a tick that needs a new due time
    assign faster    = (count_reg[ch] >= cfg.ideal_queue_depth);
    assign pct_start = (faster != speeding_reg[ch]) ? SCALE_UNITY : pct_reg[ch];

    always_comb begin
        pct_stepped = pct_start;
        if (faster) begin
            if (pct_start > SCALE_FLOOR) begin
                pct_stepped = pct_start - SCALE_STEP;
            end
        end else begin
            if (pct_start < SCALE_CEIL) begin
                pct_stepped = pct_start + SCALE_STEP;
            end
        end
    end

    // base * pct / 100
    assign scaled     = PROD_W'(base_reg[ch]) * PROD_W'(pct_stepped);
    assign scaled_div = DIV_PROD_W'(scaled) * DIV_PROD_W'(DIV100_MUL);
    assign dt         = scaled_div[DIV100_SHIFT +: DT_W];

    always_comb begin
        count_next      = count_reg[ch];
        speeding_next   = speeding_reg[ch];
        pct_next        = pct_reg[ch];
        base_next       = base_reg[ch];
        due_time_next   = due_time_reg[ch];
        due_valid_next  = due_valid_reg[ch];
        last_shown_next = last_shown_reg[ch];
        first_tick_next = first_tick_reg[ch];
        seen_next       = seen_reg[ch];
        has_shown_next  = has_shown_reg[ch];
        res             = '0;

        case (item.op)
            OP_TICK: begin
                if (seen_reg[ch]) begin
                    if (first_tick_reg[ch]) begin
                        first_tick_next = 1'b0;
                        base_next       = cfg.frame_interval;
                        due_time_next   = item.now_time;
                        due_valid_next  = 1'b1;
                    end else if (!due_valid_reg[ch]) begin
                        speeding_next  = faster;
                        pct_next       = pct_stepped;
                        due_time_next  = last_shown_reg[ch] + TIME_W'(dt);
                        due_valid_next = 1'b1;
                    end
                    res.present_due = (count_reg[ch] != '0) && due_valid_next &&
                                      (item.now_time >= due_time_next);
                end
            end
            OP_ARRIVE: begin
                seen_next = 1'b1;
                if (count_reg[ch] >= COUNT_W'(QUEUE_DEPTH)) begin
                    res.dropped = 1'b1;
                end else begin
                    count_next = count_reg[ch] + COUNT_W'(1);
                end
            end
            OP_PRESENT: begin
                if (count_reg[ch] != '0) begin
                    count_next     = count_reg[ch] - COUNT_W'(1);
                    has_shown_next = 1'b1;
                    res.shown      = 1'b1;
                end else if (has_shown_reg[ch]) begin
                    // repeat the last frame
                    res.shown = 1'b1;
                end
                if (res.shown) begin
                    last_shown_next = item.now_time;
                    due_valid_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase

        res.queue_count    = count_next;
        res.adjust_percent = pct_next;

        if (!ch_ok) begin
            res                = '0;
            res.adjust_percent = SCALE_UNITY;
        end
    end

    assign result = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                count_reg[i]      <= '0;
                speeding_reg[i]   <= 1'b0;
                pct_reg[i]        <= SCALE_UNITY;
                base_reg[i]       <= '0;
                due_time_reg[i]   <= '0;
                due_valid_reg[i]  <= 1'b0;
                last_shown_reg[i] <= '0;
                first_tick_reg[i] <= 1'b1;
                seen_reg[i]       <= 1'b0;
                has_shown_reg[i]  <= 1'b0;
            end
        end else if (item_en && ch_ok) begin
            count_reg[ch]      <= count_next;
            speeding_reg[ch]   <= speeding_next;
            pct_reg[ch]        <= pct_next;
            base_reg[ch]       <= base_next;
            due_time_reg[ch]   <= due_time_next;
            due_valid_reg[ch]  <= due_valid_next;
            last_shown_reg[ch] <= last_shown_next;
            first_tick_reg[ch] <= first_tick_next;
            seen_reg[ch]       <= seen_next;
            has_shown_reg[ch]  <= has_shown_next;
        end
    end

endmodule

`default_nettype wire

@@ design/adaptive_frame_pacing.sv @@
// An accepted item is held in the input register, then its result in the result register; a stall
// on m_tready holds both. Throughput: one item per cycle while the output is not stalled; the
// per-channel state is read, updated and written back in the cycle between the two registers, so
// items for the same channel may follow back to back.
// Reset (aresetn low, synchronous): both registers empty, frame_interval 40, ideal_queue_depth 4,
// and every channel's state returns to its reset value at once.
// Depends on afp_pkg and afp_chan_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_frame_pacing import afp_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // channel[3:0], now_time[35:4], zero pad
    input  wire logic [S_TUSER_W-1:0]   s_tuser,   // op[1:0]
    // result items
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_TDATA_W-1:0]        m_tdata    // present_due[0], shown[1],
                                                   // queue_count[6:2], adjust_percent[14:7],
                                                   // dropped[15]
);

    logic        in_valid_reg;
    afp_item_t   in_item_reg;
    logic        out_valid_reg;
    afp_result_t out_result_reg;
    afp_cfg_t    cfg_reg;

    afp_item_t   in_item_next;
    afp_result_t core_result;
    logic        advance;
    logic        in_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    assign in_item_next.op       = s_tuser[OP_W-1:0];
    assign in_item_next.channel  = s_tdata[CHANNEL_W-1:0];
    assign in_item_next.now_time = s_tdata[CHANNEL_W +: TIME_W];

    afp_chan_ctrl u_chan_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item_en (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    // Control and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            cfg_reg.frame_interval    <= FRAME_INTERVAL_RST;
            cfg_reg.ideal_queue_depth <= IDEAL_DEPTH_RST;
        end else begin
            if (in_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_index)
                    REG_FRAME_INTERVAL: cfg_reg.frame_interval <= cfg_wdata;
                    REG_IDEAL_DEPTH:    cfg_reg.ideal_queue_depth <= cfg_wdata[DEPTH_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload: hold until the next stage takes it
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_item_reg <= in_item_next;
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_result_reg);

endmodule

`default_nettype wire

@@ tb/tb_adaptive_frame_pacing.sv @@
// Self-checking bench for adaptive_frame_pacing: directed script, then randomized paced traffic.
// A per-channel predictor or literal row scores each result; depends on afp_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_adaptive_frame_pacing;
    import afp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SCRIPT_ROWS = 15;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [CHANNEL_W-1:0] ch;
        logic [TIME_W-1:0]    t;
        logic [7:0]           reps;
        logic                 lit;
        afp_result_t          want;
    } pace_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // channel[3:0], now_time[35:4], zero pad
    logic [S_TUSER_W-1:0]   s_tuser;   // op[1:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // present_due, shown, queue_count, adjust_percent, dropped

    // Predictor copy of the per-channel pacing state and the shared registers
    logic [COUNT_W-1:0]    wait_cnt   [CHANNELS];
    logic                  speeding   [CHANNELS];
    logic [PCT_W-1:0]      pct_q      [CHANNELS];
    logic [INTERVAL_W-1:0] base_iv    [CHANNELS];
    logic [TIME_W-1:0]     due_time   [CHANNELS];
    logic                  due_ok     [CHANNELS];
    logic [TIME_W-1:0]     last_show  [CHANNELS];
    logic                  first_pend [CHANNELS];
    logic                  seen_frame [CHANNELS];
    logic                  shown_once [CHANNELS];
    logic [INTERVAL_W-1:0] cur_interval;
    logic [DEPTH_W-1:0]    cur_depth;

    afp_result_t pace_expect[$];
    bit          due_seen [CHANNELS];
    bit          calm;
    bit          hold_req;
    int          errors;
    int          idle_cycles;

    int ph_interval [PHASES] = '{40, 1, 65535, 0, 100, 33, 40};
    int ph_depth    [PHASES] = '{4, 1, 16, 0, 16'hFFFF, 16'h0FE3, 4};
    int ph_arrive   [PHASES] = '{40, 30, 55, 35, 50, 40, 40};
    int ph_step     [PHASES] = '{8, 2, 3000, 5, 20, 10, 8};

    adaptive_frame_pacing uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic afp_result_t pace_event(input logic [OP_W-1:0] op,
                                               input logic [CHANNEL_W-1:0] ch,
                                               input logic [TIME_W-1:0] t);
        afp_result_t       r;
        logic              faster;
        logic [PCT_W-1:0]  pct;
        logic [TIME_W-1:0] span;
        r = '0;
        case (op)
            OP_TICK: begin
                if (seen_frame[ch]) begin
                    if (first_pend[ch]) begin
                        first_pend[ch] = 1'b0;
                        base_iv[ch]    = cur_interval;
                        due_time[ch]   = t;
                        due_ok[ch]     = 1'b1;
                    end else if (!due_ok[ch]) begin
                        faster = (wait_cnt[ch] >= cur_depth);
                        pct = pct_q[ch];
                        // direction change restarts the scale from unity
                        if (faster != speeding[ch])
                            pct = SCALE_UNITY;
                        speeding[ch] = faster;
                        if (faster) begin
                            if (pct > SCALE_FLOOR)
                                pct = pct - SCALE_STEP;
                        end else if (pct < SCALE_CEIL) begin
                            pct = pct + SCALE_STEP;
                        end
                        pct_q[ch] = pct;
                        span = (TIME_W'(base_iv[ch]) * TIME_W'(pct)) / TIME_W'(SCALE_UNITY);
                        due_time[ch] = last_show[ch] + span;
                        due_ok[ch] = 1'b1;
                    end
                    r.present_due = (wait_cnt[ch] != 0) && due_ok[ch] && (t >= due_time[ch]);
                end
            end
            OP_ARRIVE: begin
                seen_frame[ch] = 1'b1;
                if (wait_cnt[ch] >= COUNT_W'(QUEUE_DEPTH))
                    r.dropped = 1'b1;
                else
                    wait_cnt[ch] = wait_cnt[ch] + COUNT_W'(1);
            end
            OP_PRESENT: begin
                if (wait_cnt[ch] != 0) begin
                    wait_cnt[ch]   = wait_cnt[ch] - COUNT_W'(1);
                    shown_once[ch] = 1'b1;
                    r.shown        = 1'b1;
                end else if (shown_once[ch]) begin
                    r.shown = 1'b1;
                end
                if (r.shown) begin
                    last_show[ch] = t;
                    due_ok[ch]    = 1'b0;
                end
            end
            default: ;
        endcase
        r.queue_count    = wait_cnt[ch];
        r.adjust_percent = pct_q[ch];
        return r;
    endfunction

    function automatic pace_row_t row(input logic [OP_W-1:0] op, input logic [CHANNEL_W-1:0] ch,
                                      input logic [TIME_W-1:0] t, input int reps,
                                      input logic lit, input logic due, input logic sh,
                                      input int cnt, input int pct, input logic drop);
        pace_row_t x;
        x.op   = op;
        x.ch   = ch;
        x.t    = t;
        x.reps = reps[7:0];
        x.lit  = lit;
        x.want.present_due    = due;
        x.want.shown          = sh;
        x.want.queue_count    = cnt[COUNT_W-1:0];
        x.want.adjust_percent = pct[PCT_W-1:0];
        x.want.dropped        = drop;
        return x;
    endfunction

    task automatic send_event(input logic [OP_W-1:0] op, input logic [CHANNEL_W-1:0] ch,
                              input logic [TIME_W-1:0] t, input logic lit,
                              input afp_result_t want);
        afp_result_t r;
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - S_DATA_RAW_W){1'b0}}, t, ch};
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = pace_event(op, ch, t);
        if (op == OP_TICK)
            due_seen[ch] = r.present_due;
        else if (op == OP_PRESENT)
            due_seen[ch] = 1'b0;
        pace_expect.push_back(lit ? want : r);
    endtask

    // Hold the input side until every pending result is back, then let the pipe settle
    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pace_expect.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input int interval, input int depth_word);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_INTERVAL;
        cfg_wdata <= interval[CFG_DATA_W-1:0];
        @(posedge aclk);
        cur_interval = interval[INTERVAL_W-1:0];
        cfg_index <= REG_IDEAL_DEPTH;
        cfg_wdata <= depth_word[CFG_DATA_W-1:0];
        @(posedge aclk);
        cur_depth = depth_word[DEPTH_W-1:0];
        cfg_we <= 1'b0;
    endtask

    task automatic note_field(input string name, input int want, input int got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
    endtask

    // Result checker
    always @(posedge aclk) begin
        afp_result_t got;
        afp_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = afp_result_t'(m_tdata[M_DATA_RAW_W-1:0]);
            if (pace_expect.size() == 0) begin
                $display("%0t ns: result with nothing pending, actual %h", $time, got);
                errors++;
            end else begin
                want = pace_expect.pop_front();
                if (got.present_due !== want.present_due)
                    note_field("present_due", want.present_due, got.present_due);
                if (got.shown !== want.shown)
                    note_field("shown", want.shown, got.shown);
                if (got.queue_count !== want.queue_count)
                    note_field("queue_count", want.queue_count, got.queue_count);
                if (got.adjust_percent !== want.adjust_percent)
                    note_field("adjust_percent", want.adjust_percent, got.adjust_percent);
                if (got.dropped !== want.dropped)
                    note_field("dropped", want.dropped, got.dropped);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result-side back-pressure
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    initial begin
        pace_row_t            script [SCRIPT_ROWS];
        logic [TIME_W-1:0]    wall;
        logic [TIME_W-1:0]    t;
        logic [CHANNEL_W-1:0] ch;
        logic [CHANNEL_W-1:0] hot [3];
        logic [OP_W-1:0]      op;
        int                   k;

        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_wdata   <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        errors      = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            wait_cnt[c]   = '0;
            speeding[c]   = 1'b0;
            pct_q[c]      = SCALE_UNITY;
            base_iv[c]    = '0;
            due_time[c]   = '0;
            due_ok[c]     = 1'b0;
            last_show[c]  = '0;
            first_pend[c] = 1'b1;
            seen_frame[c] = 1'b0;
            shown_once[c] = 1'b0;
            due_seen[c]   = 1'b0;
        end
        cur_interval = FRAME_INTERVAL_RST;
        cur_depth    = IDEAL_DEPTH_RST;

        // op, ch, time, reps, literal?, due, shown, count, percent, dropped
        script[0]  = row(OP_TICK,    0,  0,            1,  1, 0, 0, 0,  100, 0);
        script[1]  = row(OP_PRESENT, 0,  5,            1,  1, 0, 0, 0,  100, 0);
        script[2]  = row(OP_ARRIVE,  0,  10,           1,  1, 0, 0, 1,  100, 0);
        script[3]  = row(OP_TICK,    0,  20,           1,  1, 1, 0, 1,  100, 0);
        script[4]  = row(OP_PRESENT, 0,  25,           1,  1, 0, 1, 0,  100, 0);
        script[5]  = row(OP_PRESENT, 0,  30,           1,  1, 0, 1, 0,  100, 0);
        script[6]  = row(OP_TICK,    0,  40,           1,  1, 0, 0, 0,  105, 0);
        script[7]  = row(OP_ARRIVE,  0,  50,           1,  0, 0, 0, 0,  0,   0);
        script[8]  = row(OP_TICK,    0,  72,           1,  0, 0, 0, 0,  0,   0);
        script[9]  = row(OP_ARRIVE,  15, 32'hFFFFFFF0, 16, 0, 0, 0, 0,  0,   0);
        script[10] = row(OP_ARRIVE,  15, 32'hFFFFFFF1, 1,  1, 0, 0, 16, 100, 1);
        script[11] = row(OP_TICK,    15, 32'hFFFFFFFF, 1,  1, 1, 0, 16, 100, 0);
        script[12] = row(OP_PRESENT, 15, 32'hFFFFFFFF, 1,  1, 0, 1, 15, 100, 0);
        // due time wraps past zero to 37
        script[13] = row(OP_TICK,    15, 0,            1,  1, 0, 0, 15, 95,  0);
        script[14] = row(OP_UNUSED,  15, 12345,        1,  1, 0, 0, 15, 95,  0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < SCRIPT_ROWS; r++)
            repeat (script[r].reps)
                send_event(script[r].op, script[r].ch, script[r].t, script[r].lit,
                           script[r].want);
        drain_results();

        wall = 32'd1000;
        for (int p = 0; p < PHASES; p++) begin
            configure(ph_interval[p], ph_depth[p]);
            if (p == 2)
                wall = 32'hFFF0_0000;
            else if (p == 5)
                wall = 32'hFFFF_FF00;
            if (p == PHASES - 1)
                calm = 1'b1;
            for (int h = 0; h < 3; h++)
                hot[h] = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
            if (p == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 3) == 0)
                    ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
                else
                    ch = hot[$urandom_range(0, 2)];
                wall = wall + $urandom_range(0, ph_step[p]);
                t = ($urandom_range(0, 39) == 0) ? $urandom : wall;
                k = $urandom_range(0, 99);
                // a player presents soon after a tick says a frame is due
                if (due_seen[ch] && k < 75)
                    op = OP_PRESENT;
                else if (k < ph_arrive[p])
                    op = OP_ARRIVE;
                else if (k < ph_arrive[p] + 35)
                    op = OP_TICK;
                else if (k < 96)
                    op = OP_PRESENT;
                else
                    op = OP_UNUSED;
                send_event(op, ch, t, 1'b0, '0);
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (errors == 0 && pace_expect.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
